// ----- sv/topk_merge_dedup_core_assert.svh -----
// ----------------------------------------------------------------------------
// topk_merge_dedup_core_assert.svh
// Assertion macros shared by the top-k merge block.
// ----------------------------------------------------------------------------
`ifndef TOPK_MERGE_DEDUP_CORE_ASSERT_SVH
`define TOPK_MERGE_DEDUP_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define TMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define TMD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- sv/tmd_pkg.sv -----
// ----------------------------------------------------------------------------
// tmd_pkg
// Types and constants for the top-k merge and dedup block.
// ----------------------------------------------------------------------------
package tmd_pkg;

  localparam int RESULT_COUNT = 10;
  localparam int DIST_W       = 32;
  localparam int ID_W         = 60;
  localparam int RAW_ID_W     = 61;
  localparam int CENTROID_BIT = 60;

  localparam logic KIND_CANDIDATE = 1'b0;
  localparam logic KIND_FINISH    = 1'b1;

  // One (distance, id) pair; packed so that a plain compare orders it
  typedef struct packed {
    logic [DIST_W-1:0] dkey;
    logic [ID_W-1:0]   id;
  } pair_t;

  // One list entry
  typedef struct packed {
    logic  used;
    pair_t pair;
  } slot_t;

  // One entry of the output shift chain
  typedef struct packed {
    logic            valid;
    logic            last;
    logic [ID_W-1:0] id;
  } emit_t;

  // Per-cycle commands broadcast to every cell
  typedef struct packed {
    logic insert;  // a non-duplicate candidate request goes into the list
    logic flush;   // finish request: copy list to the output chain and clear
    logic shift;   // output request taken: the output chain moves one rank
  } cell_ctrl_t;

  // Compare flags a cell hands to its right neighbor
  typedef struct packed {
    logic gt;  // entry used and greater than the candidate
    logic lt;  // entry used and less than the candidate
  } cmp_t;

endpackage

// ----- sv/tmd_cell.sv -----
// ----------------------------------------------------------------------------
// tmd_cell
// One rank of the sorted list plus one stage of the output shift chain.
// ----------------------------------------------------------------------------
module tmd_cell (
  input  logic               clk,
  input  logic               rst,
  input  tmd_pkg::cell_ctrl_t ctrl,
  input  tmd_pkg::pair_t     cand,
  input  logic               tail,
  input  tmd_pkg::slot_t     left_slot,
  input  tmd_pkg::cmp_t      left_cmp,
  input  tmd_pkg::emit_t     right_emit,
  output tmd_pkg::slot_t     slot,
  output tmd_pkg::cmp_t      cmp,
  output logic               eq,
  output tmd_pkg::emit_t     emit
);
  import tmd_pkg::*;

  logic take_cand;

  // Compare the stored pair against the broadcast candidate
  always_comb begin
    cmp.gt = slot.used && (slot.pair > cand);
    cmp.lt = slot.used && (slot.pair < cand);
    eq     = slot.used && (slot.pair == cand);
  end

  // Candidate lands here when the left entry is smaller and this one is not
  assign take_cand = left_cmp.lt && !cmp.lt;

  // List entry: shift right from the neighbor, take the candidate, or clear
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.used <= 1'b0;
    end else if (ctrl.flush) begin
      slot.used <= 1'b0;
    end else if (ctrl.insert) begin
      if (left_cmp.gt) begin
        slot <= left_slot;
      end else if (take_cand) begin
        slot.used <= 1'b1;
        slot.pair <= cand;
      end
    end
  end

  // Output chain stage: load on flush, move toward rank 0 on shift
  always_ff @(posedge clk) begin
    if (ctrl.flush) begin
      emit.valid <= slot.used;
      emit.last  <= tail;
      emit.id    <= slot.used ? slot.pair.id : '0;
    end else if (ctrl.shift) begin
      emit <= right_emit;
    end
  end

endmodule

// ----- sv/topk_merge_dedup_core.sv -----
// A candidate is folded into the list at the edge that accepts it. A finish
// request puts rank 0 on the output in the cycle after it is accepted; the
// ranks follow at one per cycle while emit_stall is low, RESULT_COUNT per finish.
// Throughput: one request per cycle; a finish waits only while the previous
// list is still draining through the output shift chain.
// Reset: synchronous, clears the list and the busy flag; the output chain has no reset.
// ----------------------------------------------------------------------------
// topk_merge_dedup_core
// Top-k merge with exact-duplicate removal, built as a chain of list cells.
// ----------------------------------------------------------------------------
module topk_merge_dedup_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          kind,
  input  logic [tmd_pkg::DIST_W-1:0]    distance_key,
  input  logic [tmd_pkg::RAW_ID_W-1:0]  item_id,
  input  logic                          id_present,
  input  logic                          from_coarse_list,
  output logic                          emit_valid,
  input  logic                          emit_stall,
  output logic [tmd_pkg::ID_W-1:0]      result_id,
  output logic                          result_valid,
  output logic                          last
);
  import tmd_pkg::*;

  `include "topk_merge_dedup_core_assert.svh"

  logic                    busy;
  logic                    busy_next;
  logic                    item_acc;
  logic                    emit_acc;
  logic                    finish_acc;
  logic                    cand_ok;
  logic                    dup;
  pair_t                   cand;
  cell_ctrl_t              ctrl;
  slot_t                   slots [RESULT_COUNT];
  cmp_t                    cmps  [RESULT_COUNT];
  emit_t                   emits [RESULT_COUNT+1];
  logic [RESULT_COUNT-1:0] eqs;
  logic [RESULT_COUNT-1:0] used_vec;
  logic [RESULT_COUNT-1:0] used_inc;

  // Handshakes; a finish may reload the chain as its final rank leaves
  assign emit_acc   = emit_valid && !emit_stall;
  assign item_stall = item_valid && (kind == KIND_FINISH) && busy &&
                      !(emit_acc && emits[0].last);
  assign item_acc   = item_valid && !item_stall;
  assign finish_acc = item_acc && (kind == KIND_FINISH);

  // Candidate filtering: absent ids and coarse-list centroids are dropped
  assign cand.dkey = distance_key;
  assign cand.id   = item_id[ID_W-1:0];
  assign cand_ok   = (kind == KIND_CANDIDATE) && id_present &&
                     !(from_coarse_list && item_id[CENTROID_BIT]);
  assign dup       = |eqs;

  assign ctrl.insert = item_acc && cand_ok && !dup;
  assign ctrl.flush  = finish_acc;
  assign ctrl.shift  = emit_acc;

  assign emits[RESULT_COUNT] = '0;

  // Row of list cells, rank 0 on the left
  for (genvar r = 0; r < RESULT_COUNT; r++) begin : g_cell
    slot_t left_slot;
    cmp_t  left_cmp;

    if (r == 0) begin : g_head
      assign left_slot = '0;
      assign left_cmp  = '{gt: 1'b0, lt: 1'b1};
    end else begin : g_body
      assign left_slot = slots[r-1];
      assign left_cmp  = cmps[r-1];
    end

    tmd_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .cand       (cand),
      .tail       (r == RESULT_COUNT - 1),
      .left_slot  (left_slot),
      .left_cmp   (left_cmp),
      .right_emit (emits[r+1]),
      .slot       (slots[r]),
      .cmp        (cmps[r]),
      .eq         (eqs[r]),
      .emit       (emits[r])
    );

    assign used_vec[r] = slots[r].used;
  end

  // Output chain occupancy
  always_comb begin
    busy_next = busy;
    if (finish_acc) begin
      busy_next = 1'b1;
    end else if (emit_acc && emits[0].last) begin
      busy_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= busy_next;
    end
  end

  assign emit_valid   = busy;
  assign result_id    = emits[0].id;
  assign result_valid = emits[0].valid;
  assign last         = emits[0].last;

  // Used entries must form a prefix starting at rank 0
  assign used_inc = used_vec + RESULT_COUNT'(1);

  `TMD_ASSERT(a_used_prefix, (used_vec & used_inc) == '0, "list entries not a prefix")
  `TMD_ASSERT_NEXT(a_flush_clears, finish_acc, used_vec == '0, "list not cleared on finish")
  `TMD_ASSERT_NEXT(a_drain_ends, emit_acc && last && !finish_acc, !emit_valid, "output past last rank")
  `TMD_ASSERT_NEXT(a_flush_loads, finish_acc, emit_valid, "finish did not start output")

endmodule
